// File: sv/assert_macros.svh
// assertion macros shared by the triangle face normal rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ASSERT_SYNC(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// clocked check that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("reset check failed");

`endif

// File: sv/tfn_pkg.sv
// constants shared by the triangle face normal pipeline
// no dependencies
`default_nettype none
package tfn_pkg;
    localparam int NORM_BITS = 31;   // scaled cross magnitudes are below 2^31
    localparam int SQ_BITS   = 64;   // sum of three squares
    localparam int ROOT_BITS = 32;   // integer square root of SQ_BITS
    localparam int OUT_WIDTH = 16;   // result component width
    localparam int OUT_MAX   = 32767;
    localparam int LANES     = 3;
endpackage
`default_nettype wire

// File: sv/tfn_cross.sv
// edge vectors, cross product and component magnitudes, four register stages
// depends on tfn_pkg
`default_nettype none
module tfn_cross #(
    parameter int CW = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic signed [CW-1:0]    ax,
    input  wire logic signed [CW-1:0]    ay,
    input  wire logic signed [CW-1:0]    az,
    input  wire logic signed [CW-1:0]    bx,
    input  wire logic signed [CW-1:0]    by_coord,
    input  wire logic signed [CW-1:0]    bz,
    input  wire logic signed [CW-1:0]    cx,
    input  wire logic signed [CW-1:0]    cy,
    input  wire logic signed [CW-1:0]    cz,
    output logic                         out_valid,
    output logic [tfn_pkg::LANES-1:0][2*CW+1:0] mag,
    output logic [tfn_pkg::LANES-1:0]    neg
);
    import tfn_pkg::*;

    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int XW = PW + 1;
    localparam int MW = XW - 1;

    logic [3:0]             v_reg;
    logic signed [EW-1:0]   e1_reg [LANES];
    logic signed [EW-1:0]   e2_reg [LANES];
    logic signed [EW-1:0]   e1_next [LANES];
    logic signed [EW-1:0]   e2_next [LANES];
    logic signed [PW-1:0]   p_reg [6];
    logic signed [PW-1:0]   p_next [6];
    logic signed [XW-1:0]   c_reg [LANES];
    logic signed [XW-1:0]   c_next [LANES];
    logic [XW-1:0]          abs_v [LANES];
    logic [LANES-1:0][MW-1:0] mag_reg;
    logic [LANES-1:0]       neg_reg;

    always_comb begin
        e1_next[0] = {bx[CW-1], bx} - {ax[CW-1], ax};
        e1_next[1] = {by_coord[CW-1], by_coord} - {ay[CW-1], ay};
        e1_next[2] = {bz[CW-1], bz} - {az[CW-1], az};
        e2_next[0] = {cx[CW-1], cx} - {ax[CW-1], ax};
        e2_next[1] = {cy[CW-1], cy} - {ay[CW-1], ay};
        e2_next[2] = {cz[CW-1], cz} - {az[CW-1], az};
    end

    always_comb begin
        p_next[0] = e1_reg[1] * e2_reg[2];
        p_next[1] = e1_reg[2] * e2_reg[1];
        p_next[2] = e1_reg[2] * e2_reg[0];
        p_next[3] = e1_reg[0] * e2_reg[2];
        p_next[4] = e1_reg[0] * e2_reg[1];
        p_next[5] = e1_reg[1] * e2_reg[0];
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            c_next[i] = {p_reg[2*i][PW-1], p_reg[2*i]}
                      - {p_reg[2*i+1][PW-1], p_reg[2*i+1]};
            abs_v[i] = c_reg[i][XW-1] ? (~c_reg[i] + 1'b1) : c_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                e1_reg[i]  <= e1_next[i];
                e2_reg[i]  <= e2_next[i];
                c_reg[i]   <= c_next[i];
                mag_reg[i] <= abs_v[i][MW-1:0];
                neg_reg[i] <= c_reg[i][XW-1];
            end
            for (int j = 0; j < 6; j++) begin
                p_reg[j] <= p_next[j];
            end
        end
    end

    assign out_valid = v_reg[3];
    assign mag       = mag_reg;
    assign neg       = neg_reg;
endmodule
`default_nettype wire

// File: sv/tfn_norm.sv
// scales the cross magnitudes to a common 31-bit range and sums their squares
// depends on tfn_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module tfn_norm #(
    parameter int CW = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic [tfn_pkg::LANES-1:0][2*CW+1:0] mag,
    input  wire logic [tfn_pkg::LANES-1:0]           neg,
    output logic                                     out_valid,
    output logic [tfn_pkg::LANES-1:0][tfn_pkg::NORM_BITS-1:0] m,
    output logic [tfn_pkg::LANES-1:0]                m_neg,
    output logic                                     deg,
    output logic [tfn_pkg::SQ_BITS-1:0]              l2
);
    import tfn_pkg::*;

    localparam int MW = 2 * CW + 2;
    localparam int BW = $clog2(MW + 1);
    localparam int SW = MW + NORM_BITS;
    localparam int QW = 2 * NORM_BITS;

    logic [3:0]                         v_reg;
    logic [MW-1:0]                      or_v;
    logic [BW-1:0]                      bl_next;
    logic [BW-1:0]                      bl_reg;
    logic [LANES-1:0][MW-1:0]           mag1_reg;
    logic [SW-1:0]                      ext_v [LANES];
    logic [LANES-1:0][NORM_BITS-1:0]    m2_reg, m3_reg, m4_reg;
    logic [QW-1:0]                      sq_reg [LANES];
    logic [SQ_BITS-1:0]                 l2_reg;
    logic [LANES-1:0]                   neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic                               deg2_reg, deg3_reg, deg4_reg;

    // leading one of the largest magnitude
    always_comb begin
        or_v    = mag[0] | mag[1] | mag[2];
        bl_next = '0;
        for (int i = 0; i < MW; i++) begin
            if (or_v[i]) begin
                bl_next = BW'(i + 1);
            end
        end
    end

    // mag * 2^(31 - bitlen), floor
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            ext_v[i] = {mag1_reg[i], {NORM_BITS{1'b0}}} >> bl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bl_reg   <= bl_next;
            mag1_reg <= mag;
            neg1_reg <= neg;
            for (int i = 0; i < LANES; i++) begin
                m2_reg[i] <= ext_v[i][NORM_BITS-1:0];
                sq_reg[i] <= m2_reg[i] * m2_reg[i];
            end
            neg2_reg <= neg1_reg;
            deg2_reg <= (bl_reg == '0);
            m3_reg   <= m2_reg;
            neg3_reg <= neg2_reg;
            deg3_reg <= deg2_reg;
            l2_reg   <= SQ_BITS'(sq_reg[0]) + SQ_BITS'(sq_reg[1]) + SQ_BITS'(sq_reg[2]);
            m4_reg   <= m3_reg;
            neg4_reg <= neg3_reg;
            deg4_reg <= deg3_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign m         = m4_reg;
    assign m_neg     = neg4_reg;
    assign deg       = deg4_reg;
    assign l2        = l2_reg;

    // the largest scaled magnitude has its top bit set unless the triangle is degenerate
    `ASSERT_SYNC(a_norm_top_bit, aclk, aresetn, v_reg[1] && !deg2_reg |-> (m2_reg[0][NORM_BITS-1] || m2_reg[1][NORM_BITS-1] || m2_reg[2][NORM_BITS-1]))
    `ASSERT_SYNC(a_norm_zero, aclk, aresetn, v_reg[1] && deg2_reg |-> (m2_reg == '0))
    `ASSERT_ALWAYS(a_norm_reset, aclk, !aresetn |=> (v_reg == '0))
endmodule
`default_nettype wire

// File: sv/tfn_sqrt.sv
// pipelined integer square root, one result bit per register stage
// depends on tfn_pkg
`default_nettype none
module tfn_sqrt #(
    parameter int SIDE_W = 97
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [tfn_pkg::SQ_BITS-1:0]    rad_in,
    input  wire logic [SIDE_W-1:0]              side_in,
    output logic                                out_valid,
    output logic [tfn_pkg::ROOT_BITS-1:0]       root_out,
    output logic [SIDE_W-1:0]                   side_out
);
    import tfn_pkg::*;

    localparam int RW = ROOT_BITS + 2;
    localparam int TW = RW + 2;

    logic                   v_reg    [0:ROOT_BITS];
    logic [SQ_BITS-1:0]     rad_reg  [0:ROOT_BITS];
    logic [RW-1:0]          rem_reg  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0]   root_reg [0:ROOT_BITS];
    logic [SIDE_W-1:0]      side_reg [0:ROOT_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg[0]  <= rad_in;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
        logic [TW-1:0] rem_t;
        logic [TW-1:0] trial;
        logic [TW-1:0] diff;
        logic          ge;

        always_comb begin
            rem_t = {rem_reg[k], rad_reg[k][SQ_BITS-1 -: 2]};
            trial = {2'b00, root_reg[k], 2'b01};
            diff  = rem_t - trial;
            ge    = (rem_t >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k+1]  <= {rad_reg[k][SQ_BITS-3:0], 2'b00};
                rem_reg[k+1]  <= ge ? diff[RW-1:0] : rem_t[RW-1:0];
                root_reg[k+1] <= {root_reg[k][ROOT_BITS-2:0], ge};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[ROOT_BITS];
    assign root_out  = root_reg[ROOT_BITS];
    assign side_out  = side_reg[ROOT_BITS];
endmodule
`default_nettype wire

// File: sv/tfn_div.sv
// three restoring dividers, one quotient bit per stage, then saturation and sign
// depends on tfn_pkg
`default_nettype none
module tfn_div #(
    parameter int F = 14
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          en,
    input  wire logic                                          in_valid,
    input  wire logic [tfn_pkg::LANES-1:0][tfn_pkg::NORM_BITS-1:0] m,
    input  wire logic [tfn_pkg::LANES-1:0]                     m_neg,
    input  wire logic                                          deg,
    input  wire logic [tfn_pkg::ROOT_BITS-1:0]                 len,
    output logic                                               out_valid,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0]               nx,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0]               ny,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0]               nz,
    output logic                                               degenerate
);
    import tfn_pkg::*;

    localparam int QW  = F + 2;
    localparam int NW  = NORM_BITS + F + 1;
    localparam int HW  = NW - QW;
    localparam int LIM = (F >= 15) ? OUT_MAX : (1 << F);
    localparam logic [QW-1:0] LIM_Q = QW'(LIM);

    logic                               v_reg    [0:QW];
    logic [LANES-1:0][ROOT_BITS-1:0]    rem_reg  [0:QW];
    logic [LANES-1:0][QW-1:0]           low_reg  [0:QW];
    logic [LANES-1:0][QW-1:0]           q_reg    [0:QW];
    logic [ROOT_BITS-1:0]               len_reg  [0:QW];
    logic [LANES-1:0]                   neg_reg  [0:QW];
    logic                               deg_reg  [0:QW];

    logic [NW-1:0]                      num_v [LANES];
    logic                               out_v_reg;
    logic signed [OUT_WIDTH-1:0]        n_reg [LANES];
    logic signed [OUT_WIDTH-1:0]        n_next [LANES];
    logic                               deg_out_reg;
    logic [QW-1:0]                      qs_v [LANES];

    // numerator m * 2^F + floor(len / 2); its top part is already below len
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            num_v[i] = {m[i], {F{1'b0}}} + NW'(len >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                rem_reg[0][i] <= ROOT_BITS'(num_v[i][NW-1 -: HW]);
                low_reg[0][i] <= num_v[i][QW-1:0];
                q_reg[0][i]   <= '0;
            end
            len_reg[0] <= len;
            neg_reg[0] <= m_neg;
            deg_reg[0] <= deg;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [ROOT_BITS:0] rem_t [LANES];
        logic [ROOT_BITS:0] diff  [LANES];
        logic [LANES-1:0]   ge;

        always_comb begin
            for (int i = 0; i < LANES; i++) begin
                rem_t[i] = {rem_reg[k][i], low_reg[k][i][QW-1]};
                diff[i]  = rem_t[i] - {1'b0, len_reg[k]};
                ge[i]    = (rem_t[i] >= {1'b0, len_reg[k]});
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < LANES; i++) begin
                    rem_reg[k+1][i] <= ge[i] ? diff[i][ROOT_BITS-1:0]
                                             : rem_t[i][ROOT_BITS-1:0];
                    low_reg[k+1][i] <= {low_reg[k][i][QW-2:0], 1'b0};
                    q_reg[k+1][i]   <= {q_reg[k][i][QW-2:0], ge[i]};
                end
                len_reg[k+1] <= len_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                deg_reg[k+1] <= deg_reg[k];
            end
        end
    end

    // clamp to one (or the output range), apply the sign, zero on degenerate
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            qs_v[i] = (q_reg[QW][i] > LIM_Q) ? LIM_Q : q_reg[QW][i];
            if (deg_reg[QW]) begin
                n_next[i] = '0;
            end else if (neg_reg[QW][i]) begin
                n_next[i] = -OUT_WIDTH'(qs_v[i]);
            end else begin
                n_next[i] = OUT_WIDTH'(qs_v[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= v_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                n_reg[i] <= n_next[i];
            end
            deg_out_reg <= deg_reg[QW];
        end
    end

    assign out_valid  = out_v_reg;
    assign nx         = n_reg[0];
    assign ny         = n_reg[1];
    assign nz         = n_reg[2];
    assign degenerate = deg_out_reg;
endmodule
`default_nettype wire

// File: sv/triangle_face_normal.sv
// top level of the triangle face normal pipeline
// depends on tfn_pkg, tfn_cross, tfn_norm, tfn_sqrt, tfn_div and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
// Takes one triangle (three Q8.8 vertices) per transaction and returns its unit face
// normal in Q2.14 plus a degenerate flag, which is set with a zero normal when the
// cross product vanishes. A new transaction is taken every clock while s_ready is
// high. The pipeline runs the edges and cross product, the scaling and squares, the square
// root (one bit per stage), then the division (one quotient bit per stage) and the
// output register. The whole pipeline advances together: no stage moves while a
// result is presented and not taken, so s_ready follows m_ready or an empty output
// register.
module triangle_face_normal #(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [COORD_WIDTH-1:0]       s_ax,
    input  wire logic signed [COORD_WIDTH-1:0]       s_ay,
    input  wire logic signed [COORD_WIDTH-1:0]       s_az,
    input  wire logic signed [COORD_WIDTH-1:0]       s_bx,
    input  wire logic signed [COORD_WIDTH-1:0]       s_by_coord,
    input  wire logic signed [COORD_WIDTH-1:0]       s_bz,
    input  wire logic signed [COORD_WIDTH-1:0]       s_cx,
    input  wire logic signed [COORD_WIDTH-1:0]       s_cy,
    input  wire logic signed [COORD_WIDTH-1:0]       s_cz,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0]     m_nx,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0]     m_ny,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0]     m_nz,
    output logic                                     m_degenerate
);
    import tfn_pkg::*;

    localparam int MW     = 2 * COORD_WIDTH + 2;
    localparam int SIDE_W = LANES * NORM_BITS + LANES + 1;
    localparam int LIM    = (NORMAL_FRAC_BITS >= 15) ? OUT_MAX : (1 << NORMAL_FRAC_BITS);
    localparam logic signed [OUT_WIDTH-1:0] LIM_S = OUT_WIDTH'(LIM);

    logic                               en;
    logic                               x_valid;
    logic [LANES-1:0][MW-1:0]           x_mag;
    logic [LANES-1:0]                   x_neg;
    logic                               n_valid;
    logic [LANES-1:0][NORM_BITS-1:0]    n_m;
    logic [LANES-1:0]                   n_neg;
    logic                               n_deg;
    logic [SQ_BITS-1:0]                 n_l2;
    logic                               r_valid;
    logic [ROOT_BITS-1:0]               r_len;
    logic [SIDE_W-1:0]                  r_side;

    // one enable for every stage
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    tfn_cross #(.CW(COORD_WIDTH)) u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .ax        (s_ax),
        .ay        (s_ay),
        .az        (s_az),
        .bx        (s_bx),
        .by_coord  (s_by_coord),
        .bz        (s_bz),
        .cx        (s_cx),
        .cy        (s_cy),
        .cz        (s_cz),
        .out_valid (x_valid),
        .mag       (x_mag),
        .neg       (x_neg)
    );

    tfn_norm #(.CW(COORD_WIDTH)) u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (x_valid),
        .mag       (x_mag),
        .neg       (x_neg),
        .out_valid (n_valid),
        .m         (n_m),
        .m_neg     (n_neg),
        .deg       (n_deg),
        .l2        (n_l2)
    );

    tfn_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n_valid),
        .rad_in    (n_l2),
        .side_in   ({n_m, n_neg, n_deg}),
        .out_valid (r_valid),
        .root_out  (r_len),
        .side_out  (r_side)
    );

    tfn_div #(.F(NORMAL_FRAC_BITS)) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (r_valid),
        .m          (r_side[SIDE_W-1 -: LANES*NORM_BITS]),
        .m_neg      (r_side[LANES:1]),
        .deg        (r_side[0]),
        .len        (r_len),
        .out_valid  (m_valid),
        .nx         (m_nx),
        .ny         (m_ny),
        .nz         (m_nz),
        .degenerate (m_degenerate)
    );

    `ASSERT_SYNC(a_deg_zero, aclk, aresetn,
        m_valid && m_degenerate |-> (m_nx == 0 && m_ny == 0 && m_nz == 0))
    `ASSERT_SYNC(a_unit_bound, aclk, aresetn,
        m_valid |-> (m_nx <= LIM_S && m_nx >= -LIM_S && m_ny <= LIM_S &&
                     m_ny >= -LIM_S && m_nz <= LIM_S && m_nz >= -LIM_S))
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)
endmodule
`default_nettype wire
